// ===== design/gses_pkg.sv =====
// Package for the grayscale Sobel edge stream: widths, defaults, gray and sqrt helpers.
// No dependencies.
package gses_pkg;
   localparam int MaxLinePixels  = 2048;
   localparam int MaxFrameLines  = 2048;
   localparam int CsrWidth       = 12;
   localparam int CoordWidth     = 11;
   localparam int SqrtCells      = 8;
   localparam logic [CsrWidth-1:0] ResetWidth  = 12'd640;
   localparam logic [CsrWidth-1:0] ResetHeight = 12'd480;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // one sqrt digit step: remainder, root and tag move through the cell row
   typedef struct packed {
      logic                  valid;
      logic [16:0]           rem;
      logic [15:0]           root;
      logic                  sat;
      logic [CoordWidth-1:0] row;
      logic [CoordWidth-1:0] col;
      logic                  last;
   } sqrt_word_type;

   function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [15:0] s;
      s = 16'(r) * 16'd77 + 16'(g) * 16'd150 + 16'(b) * 16'd29;
      return s[15:8];
   endfunction
endpackage

// ===== design/gses_sqrt_cell.sv =====
// One cell of the square root chain: retires one root bit per cycle while advance is high.
// Depends on gses_pkg.
module gses_sqrt_cell import gses_pkg::*; #(
   parameter int unsigned Step = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  sqrt_word_type word_in,
   output sqrt_word_type word_out
);
   localparam logic [16:0] Bit = 17'(1) << (14 - 2*Step);
   sqrt_word_type word_ff, word_in_nx;
   logic [16:0] trial;

   always_comb begin
      word_in_nx = word_in;
      trial = 17'(word_in.root) + Bit;
      if (word_in.rem >= trial) begin
         word_in_nx.rem  = word_in.rem - trial;
         word_in_nx.root = 16'((17'(word_in.root) >> 1) + Bit);
      end else begin
         word_in_nx.root = word_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in_nx;
      end
   end

   assign word_out = word_ff;
endmodule

// ===== design/gses_window.sv =====
// Gray conversion, line stores, 3x3 window and Sobel sum of squares.
// Depends on gses_pkg; feeds the sqrt cell chain.
module gses_window import gses_pkg::*; #(
   parameter int unsigned MaxLine = MaxLinePixels
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                take,
   input  logic [7:0]          red,
   input  logic [7:0]          green,
   input  logic [7:0]          blue,
   input  logic [CsrWidth-1:0] width_cfg,
   input  logic [CsrWidth-1:0] height_cfg,
   output sqrt_word_type       word_out
);
   localparam int AW = $clog2(MaxLine);
   localparam int CW = $clog2(MaxLine + 1) > 13 ? $clog2(MaxLine + 1) : 13;

   logic [7:0] upper_mem [MaxLine];
   logic [7:0] middle_mem [MaxLine];

   // stage 1: position, gray, store read
   logic [CW-1:0] w_eff, h_eff, r_cur, c_cur;
   logic [CW-1:0] row_ff, row_in, col_ff, col_in;
   logic          s1_valid_ff;
   logic [7:0]    gray_ff, up_ff, mid_ff;
   logic [CW-1:0] s1_row_ff, s1_col_ff;
   logic          s1_last_ff;
   logic [7:0]    win_ff [3][3];
   logic          s2_valid_ff, s2_last_ff;
   logic [CW-1:0] s2_row_ff, s2_col_ff;
   logic signed [11:0] gx, gy;
   sqrt_word_type sq_ff;
   logic [21:0]   sq;

   always_comb begin
      w_eff = (width_cfg < 12'd3) ? CW'(3) :
              (CW'(width_cfg) > CW'(MaxLine)) ? CW'(MaxLine) : CW'(width_cfg);
      h_eff = (height_cfg < 12'd3) ? CW'(3) :
              (CW'(height_cfg) > CW'(MaxFrameLines)) ? CW'(MaxFrameLines) : CW'(height_cfg);
      r_cur = row_ff;
      c_cur = col_ff;
      if (c_cur >= w_eff) begin
         c_cur = '0;
         r_cur = r_cur + 1'b1;
      end
      if (r_cur >= h_eff) r_cur = '0;
      col_in = c_cur + 1'b1;
      row_in = r_cur;
      if (col_in >= w_eff) begin
         col_in = '0;
         row_in = r_cur + 1'b1;
         if (row_in >= h_eff) row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= take;
         if (take) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   // upper line takes the registered middle read, written back at the stage 1 column when stage 1 advances
   always_ff @(posedge clock) begin
      if (advance && take) begin
         up_ff   <= upper_mem[c_cur[AW-1:0]];
         mid_ff  <= middle_mem[c_cur[AW-1:0]];
         middle_mem[c_cur[AW-1:0]] <= gray_of(red, green, blue);
         gray_ff   <= gray_of(red, green, blue);
         s1_row_ff <= r_cur;
         s1_col_ff <= c_cur;
         s1_last_ff <= (r_cur == h_eff - 1'b1) && (c_cur == w_eff - 1'b1);
      end
      if (advance && s1_valid_ff) begin
         upper_mem[s1_col_ff[AW-1:0]] <= mid_ff;
      end
   end

   // stage 2: window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win_ff[i][j] <= '0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_row_ff >= CW'(2) && s1_col_ff >= CW'(2);
         if (s1_valid_ff) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= up_ff;
            win_ff[1][2] <= mid_ff;
            win_ff[2][2] <= gray_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         s2_row_ff  <= s1_row_ff - 1'b1;
         s2_col_ff  <= s1_col_ff - 1'b1;
         s2_last_ff <= s1_last_ff;
      end
   end

   // stage 3: kernels and squares
   always_comb begin
      gx = (12'(win_ff[0][2]) + (12'(win_ff[1][2]) << 1) + 12'(win_ff[2][2]))
         - (12'(win_ff[0][0]) + (12'(win_ff[1][0]) << 1) + 12'(win_ff[2][0]));
      gy = (12'(win_ff[2][0]) + (12'(win_ff[2][1]) << 1) + 12'(win_ff[2][2]))
         - (12'(win_ff[0][0]) + (12'(win_ff[0][1]) << 1) + 12'(win_ff[0][2]));
      sq = 22'(gx) * 22'(gx) + 22'(gy) * 22'(gy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.valid <= 1'b0;
      end else if (advance) begin
         sq_ff.valid <= s2_valid_ff;
         sq_ff.rem   <= sq[16:0];
         sq_ff.root  <= '0;
         sq_ff.sat   <= sq >= 22'd65536;
         sq_ff.row   <= s2_row_ff[CoordWidth-1:0];
         sq_ff.col   <= s2_col_ff[CoordWidth-1:0];
         sq_ff.last  <= s2_last_ff;
      end
   end

   assign word_out = sq_ff;
endmodule

// ===== design/grayscale_sobel_edge_stream.sv =====
// Grayscale Sobel edge magnitude stream, top level.
// Throughput one pixel per cycle while the output is not stalled,
// set by the line store read-write port and the eight-cell square root chain.
// The pipeline moves as a whole and holds while the output is stalled.
// Synchronous reset clears counters, window and valid flags; sizes return to 640x480.
// Line stores are not cleared. Depends on gses_pkg, gses_window, gses_sqrt_cell.
module grayscale_sobel_edge_stream import gses_pkg::*; #(
   parameter int unsigned MAX_LINE_PIXELS = MaxLinePixels
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_edge_magnitude,
   output logic [CoordWidth-1:0] rsp_out_row,
   output logic [CoordWidth-1:0] rsp_out_col,
   output logic                  rsp_frame_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [CsrWidth-1:0]   csr_data
);
   logic [CsrWidth-1:0] width_ff, height_ff;
   logic advance;
   sqrt_word_type chain [SqrtCells+1];

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ResetWidth;
         height_ff <= ResetHeight;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gses_window #(.MaxLine(MAX_LINE_PIXELS)) u_window (
      .clock, .reset, .advance,
      .take(req_valid),
      .red(req_red), .green(req_green), .blue(req_blue),
      .width_cfg(width_ff), .height_cfg(height_ff),
      .word_out(chain[0])
   );

   for (genvar i = 0; i < SqrtCells; i++) begin : g_cell
      gses_sqrt_cell #(.Step(i)) u_cell (
         .clock, .reset, .advance,
         .word_in(chain[i]), .word_out(chain[i+1])
      );
   end

   assign rsp_valid          = chain[SqrtCells].valid;
   assign rsp_edge_magnitude = chain[SqrtCells].sat ? 8'hFF : chain[SqrtCells].root[7:0];
   assign rsp_out_row        = chain[SqrtCells].row;
   assign rsp_out_col        = chain[SqrtCells].col;
   assign rsp_frame_end      = chain[SqrtCells].last;
endmodule
